[rtl/sjd_pkg.sv]
// shared types, codes and default sizes for the sharded job dispatcher
// used by the front, back and top modules of the dispatcher; no dependencies
package sjd_pkg;

    localparam int MAX_WORKERS_DEF    = 16;
    localparam int SHARD_DEPTH_DEF    = 16;
    localparam int OVERFLOW_DEPTH_DEF = 64;
    localparam int JOB_W              = 16;

    typedef enum logic [2:0] {
        ACT_SUBMIT   = 3'd0,
        ACT_POP      = 3'd1,
        ACT_COMPLETE = 3'd2,
        ACT_STOP     = 3'd3,
        ACT_STATS    = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_QUEUED   = 3'd0,
        ST_DEFERRED = 3'd1,
        ST_POPPED   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_EXIT     = 3'd4,
        ST_DROPPED  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CFG_TOTAL = 2'd0,
        CFG_HEAVY = 2'd1,
        CFG_CAP   = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OVF_PUSH,
        S_MOD_ENQ,
        S_ENQ,
        S_STOP_CHK,
        S_OVF_RD,
        S_OVF_WAIT,
        S_MOD_SCAN,
        S_SCAN,
        S_POP_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]       action;
        logic [JOB_W-1:0] job_id;
        logic             job_class;
        logic [3:0]       worker_index;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       status;
        logic [JOB_W-1:0] popped_job;
        logic [3:0]       shard_used;
        logic [8:0]       queued_count;
        logic [6:0]       overflow_count;
        logic [31:0]      submitted_total;
        logic [31:0]      completed_total;
        logic [31:0]      deferred_total;
    } t_out_word;

    // classified command handed from the front to the back
    typedef struct packed {
        logic [2:0]       action;
        logic [JOB_W-1:0] job;
        logic             grp;
        logic [3:0]       widx;
    } t_cmd;

endpackage

[rtl/sjd_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module sjd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/sjd_front.sv]
// front end: accepts input words, resolves the group and queues commands
// depends on sjd_pkg
module sjd_front #(
    parameter int MAX_WORKERS = sjd_pkg::MAX_WORKERS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [$clog2(MAX_WORKERS+1)-1:0] i_heavy_size,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  sjd_pkg::t_in_word                i_in,
    output logic                             o_cmd_valid,
    input  logic                             i_cmd_ready,
    output sjd_pkg::t_cmd                    o_cmd
);
    import sjd_pkg::*;

    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cls;

    // heavy words go to the light group when the heavy group has no workers
    always_comb begin
        w_cls.action = i_in.action;
        w_cls.job    = i_in.job_id;
        w_cls.grp    = i_in.job_class && (i_heavy_size != '0);
        w_cls.widx   = i_in.worker_index;
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

[rtl/sjd_back.sv]
// back end: executes commands on the shard queues and overflow fifos
// depends on sjd_pkg and sjd_ram
module sjd_back #(
    parameter int MAX_WORKERS    = sjd_pkg::MAX_WORKERS_DEF,
    parameter int SHARD_DEPTH    = sjd_pkg::SHARD_DEPTH_DEF,
    parameter int OVERFLOW_DEPTH = sjd_pkg::OVERFLOW_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [1:0][$clog2(MAX_WORKERS+1)-1:0]  i_size,
    input  logic [8:0]                             i_queue_cap,
    input  logic                                   i_cmd_valid,
    output logic                                   o_cmd_ready,
    input  sjd_pkg::t_cmd                          i_cmd,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output sjd_pkg::t_out_word                     o_out
);
    import sjd_pkg::*;

    localparam int SW  = $clog2(MAX_WORKERS);
    localparam int NW  = $clog2(MAX_WORKERS + 1);
    localparam int XW  = (NW > 4) ? NW : 4;
    localparam int DW  = $clog2(SHARD_DEPTH);
    localparam int DCW = $clog2(SHARD_DEPTH + 1);
    localparam int OHW = $clog2(OVERFLOW_DEPTH);
    localparam int OCW = $clog2(OVERFLOW_DEPTH + 1);
    localparam int QW  = $clog2(MAX_WORKERS * SHARD_DEPTH + 1);
    localparam int CW  = (QW > 9) ? QW : 9;
    localparam int NSH = 2 << SW;
    localparam int SAW = SW + 1 + DW;
    localparam int OAW = 1 + OHW;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic             r_h, n_h;
    logic [XW-1:0]    r_x, n_x;
    logic [NW-1:0]    r_k, n_k;
    logic [JOB_W-1:0] r_job, n_job;
    t_status          r_status, n_status;
    logic [SW-1:0]    r_shard, n_shard;
    logic [JOB_W-1:0] r_popped, n_popped;
    logic [DW-1:0]    r_head [NSH];
    logic [DW-1:0]    n_head [NSH];
    logic [DCW-1:0]   r_scnt [NSH];
    logic [DCW-1:0]   n_scnt [NSH];
    logic [OHW-1:0]   r_ohead [2];
    logic [OHW-1:0]   n_ohead [2];
    logic [OCW-1:0]   r_ocnt [2];
    logic [OCW-1:0]   n_ocnt [2];
    logic [SW-1:0]    r_rr [2];
    logic [SW-1:0]    n_rr [2];
    logic [QW-1:0]    r_queued [2];
    logic [QW-1:0]    n_queued [2];
    logic [31:0]      r_sub [2];
    logic [31:0]      n_sub [2];
    logic [31:0]      r_cmp [2];
    logic [31:0]      n_cmp [2];
    logic [31:0]      r_def [2];
    logic [31:0]      n_def [2];
    logic             r_stop, n_stop;
    logic             r_out_vld, n_out_vld;
    t_out_word        r_out, n_out;

    logic             w_g;
    logic [NW-1:0]    w_n;
    logic [XW-1:0]    w_n_x;
    logic [XW-1:0]    w_x_inc;
    logic [SW-1:0]    w_s;
    logic [SW:0]      w_sidx;
    logic [DW-1:0]    w_cur_head;
    logic [DCW-1:0]   w_cur_cnt;
    logic [DCW:0]     w_ssum;
    logic [DW-1:0]    w_stail;
    logic [DW-1:0]    w_head_nx;
    logic [OHW-1:0]   w_oh;
    logic [OCW-1:0]   w_oc;
    logic [OCW:0]     w_osum;
    logic [OHW-1:0]   w_otail;
    logic [OHW-1:0]   w_ohead_nx;
    logic             w_cap_set;
    logic             w_cap_full;
    logic             w_sfull;
    logic             w_ofull;
    logic             s_we, o_we;
    logic [JOB_W-1:0] s_rdata, o_rdata;

    // group looked up: the incoming command's while idle, else the working one
    assign w_g        = (r_state == S_IDLE) ? i_cmd.grp : r_h;
    assign w_n        = i_size[w_g];
    assign w_n_x      = XW'(w_n);
    assign w_x_inc    = r_x + XW'(1);
    assign w_s        = r_x[SW-1:0];
    assign w_sidx     = {w_g, w_s};
    assign w_cur_head = r_head[w_sidx];
    assign w_cur_cnt  = r_scnt[w_sidx];
    assign w_ssum     = (DCW+1)'(w_cur_head) + (DCW+1)'(w_cur_cnt);
    assign w_stail    = (w_ssum >= (DCW+1)'(SHARD_DEPTH))
                        ? DW'(w_ssum - (DCW+1)'(SHARD_DEPTH)) : DW'(w_ssum);
    assign w_head_nx  = (w_cur_head == DW'(SHARD_DEPTH - 1)) ? '0 : w_cur_head + DW'(1);
    assign w_sfull    = (w_cur_cnt >= DCW'(SHARD_DEPTH));
    assign w_oh       = r_ohead[w_g];
    assign w_oc       = r_ocnt[w_g];
    assign w_osum     = (OCW+1)'(w_oh) + (OCW+1)'(w_oc);
    assign w_otail    = (w_osum >= (OCW+1)'(OVERFLOW_DEPTH))
                        ? OHW'(w_osum - (OCW+1)'(OVERFLOW_DEPTH)) : OHW'(w_osum);
    assign w_ohead_nx = (w_oh == OHW'(OVERFLOW_DEPTH - 1)) ? '0 : w_oh + OHW'(1);
    assign w_ofull    = (w_oc >= OCW'(OVERFLOW_DEPTH));
    assign w_cap_set  = (i_queue_cap != 9'd0);
    assign w_cap_full = w_cap_set && (CW'(r_queued[w_g]) >= CW'(i_queue_cap));

    sjd_ram #(.WIDTH(JOB_W), .DEPTH(1 << SAW)) u_shard_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr ({r_h, w_s, w_stail}),
        .i_wdata (r_job),
        .i_raddr ({r_h, w_s, w_cur_head}),
        .o_rdata (s_rdata)
    );

    sjd_ram #(.WIDTH(JOB_W), .DEPTH(1 << OAW)) u_ovf_ram (
        .i_clk   (i_clk),
        .i_we    (o_we),
        .i_waddr ({r_h, w_otail}),
        .i_wdata (r_job),
        .i_raddr ({r_h, w_oh}),
        .o_rdata (o_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (t_action'(i_cmd.action))
                        ACT_SUBMIT: begin
                            n_state = (w_cap_full && !r_stop) ? S_OVF_PUSH : S_MOD_ENQ;
                        end
                        ACT_POP: n_state = S_MOD_SCAN;
                        ACT_COMPLETE: begin
                            n_state = (!w_cap_full && w_oc != '0 && w_n != '0)
                                      ? S_OVF_RD : S_DONE;
                        end
                        ACT_STOP: n_state = r_stop ? S_DONE : S_STOP_CHK;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_OVF_PUSH: n_state = S_DONE;
            S_MOD_ENQ:  n_state = (r_x >= w_n_x) ? S_MOD_ENQ : S_ENQ;
            S_ENQ: begin
                n_state = (t_action'(r_cmd.action) == ACT_STOP) ? S_STOP_CHK : S_DONE;
            end
            S_STOP_CHK: begin
                if (w_n != '0 && w_oc != '0) begin
                    n_state = S_OVF_RD;
                end else if (r_h) begin
                    n_state = S_DONE;
                end
            end
            S_OVF_RD:   n_state = S_OVF_WAIT;
            S_OVF_WAIT: n_state = S_MOD_ENQ;
            S_MOD_SCAN: n_state = (r_x >= w_n_x) ? S_MOD_SCAN : S_SCAN;
            S_SCAN: begin
                if (w_cur_cnt != '0) begin
                    n_state = S_POP_WAIT;
                end else if (r_k + NW'(1) == w_n) begin
                    n_state = S_DONE;
                end
            end
            S_POP_WAIT: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_cmd     = r_cmd;
        n_h       = r_h;
        n_x       = r_x;
        n_k       = r_k;
        n_job     = r_job;
        n_status  = r_status;
        n_shard   = r_shard;
        n_popped  = r_popped;
        n_head    = r_head;
        n_scnt    = r_scnt;
        n_ohead   = r_ohead;
        n_ocnt    = r_ocnt;
        n_rr      = r_rr;
        n_queued  = r_queued;
        n_sub     = r_sub;
        n_cmp     = r_cmp;
        n_def     = r_def;
        n_stop    = r_stop;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_out_ready;
        s_we      = 1'b0;
        o_we      = 1'b0;
        o_cmd_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd    = i_cmd;
                    n_h      = i_cmd.grp;
                    n_job    = i_cmd.job;
                    n_shard  = '0;
                    n_popped = '0;
                    n_status = ST_QUEUED;
                    case (t_action'(i_cmd.action))
                        ACT_SUBMIT: begin
                            n_sub[w_g] = r_sub[w_g] + 32'd1;
                            if (w_cap_full && !r_stop) begin
                                n_def[w_g] = r_def[w_g] + 32'd1;
                            end
                            n_x = XW'(r_rr[w_g]);
                        end
                        ACT_POP: n_x = XW'(i_cmd.widx);
                        ACT_COMPLETE: begin
                            n_cmp[w_g] = r_cmp[w_g] + 32'd1;
                            n_status   = ST_EMPTY;
                        end
                        ACT_STOP: begin
                            n_status = ST_EXIT;
                            if (!r_stop) begin
                                n_stop = 1'b1;
                                n_h    = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_OVF_PUSH: begin
                if (!w_ofull) begin
                    o_we          = 1'b1;
                    n_ocnt[r_h]   = w_oc + OCW'(1);
                    n_status      = ST_DEFERRED;
                end else begin
                    n_status = ST_DROPPED;
                end
            end
            S_MOD_ENQ, S_MOD_SCAN: begin
                if (r_x >= w_n_x) begin
                    n_x = r_x - w_n_x;
                end else begin
                    n_k = '0;
                end
            end
            S_ENQ: begin
                // pointer moves on even when the shard is full
                n_rr[r_h] = (w_x_inc == w_n_x) ? '0 : SW'(w_x_inc);
                if (t_action'(r_cmd.action) != ACT_STOP) begin
                    n_shard = w_s;
                end
                if (w_sfull) begin
                    n_status = ST_DROPPED;
                end else begin
                    s_we           = 1'b1;
                    n_scnt[w_sidx] = w_cur_cnt + DCW'(1);
                    n_queued[r_h]  = r_queued[r_h] + QW'(1);
                    if (t_action'(r_cmd.action) != ACT_STOP) begin
                        n_status = ST_QUEUED;
                    end
                end
            end
            S_STOP_CHK: begin
                if (!(w_n != '0 && w_oc != '0) && !r_h) begin
                    n_h = 1'b1;
                end
            end
            S_OVF_RD: begin
                n_ohead[r_h] = w_ohead_nx;
                n_ocnt[r_h]  = w_oc - OCW'(1);
            end
            S_OVF_WAIT: begin
                n_job = o_rdata;
                n_x   = XW'(r_rr[r_h]);
            end
            S_SCAN: begin
                if (w_cur_cnt != '0) begin
                    n_head[w_sidx] = w_head_nx;
                    n_scnt[w_sidx] = w_cur_cnt - DCW'(1);
                    if (r_queued[r_h] != '0) begin
                        n_queued[r_h] = r_queued[r_h] - QW'(1);
                    end
                    n_shard = w_s;
                end else if (r_k + NW'(1) == w_n) begin
                    n_status = r_stop ? ST_EXIT : ST_EMPTY;
                end else begin
                    n_k = r_k + NW'(1);
                    n_x = (w_x_inc == w_n_x) ? '0 : w_x_inc;
                end
            end
            S_POP_WAIT: begin
                n_popped = s_rdata;
                n_status = ST_POPPED;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld             = 1'b1;
                    n_out.status          = r_status;
                    n_out.popped_job      = r_popped;
                    n_out.shard_used      = 4'(r_shard);
                    n_out.queued_count    = 9'(r_queued[r_cmd.grp]);
                    n_out.overflow_count  = 7'(r_ocnt[r_cmd.grp]);
                    n_out.submitted_total = r_sub[r_cmd.grp];
                    n_out.completed_total = r_cmp[r_cmd.grp];
                    n_out.deferred_total  = r_def[r_cmd.grp];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_h      <= n_h;
        r_x      <= n_x;
        r_k      <= n_k;
        r_job    <= n_job;
        r_status <= n_status;
        r_shard  <= n_shard;
        r_popped <= n_popped;
        r_out    <= n_out;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stop    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < NSH; i++) begin
                r_head[i] <= '0;
                r_scnt[i] <= '0;
            end
            for (int g = 0; g < 2; g++) begin
                r_ohead[g]  <= '0;
                r_ocnt[g]   <= '0;
                r_rr[g]     <= '0;
                r_queued[g] <= '0;
                r_sub[g]    <= '0;
                r_cmp[g]    <= '0;
                r_def[g]    <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_stop    <= n_stop;
            r_out_vld <= n_out_vld;
            r_head    <= n_head;
            r_scnt    <= n_scnt;
            r_ohead   <= n_ohead;
            r_ocnt    <= n_ocnt;
            r_rr      <= n_rr;
            r_queued  <= n_queued;
            r_sub     <= n_sub;
            r_cmp     <= n_cmp;
            r_def     <= n_def;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
endmodule

[rtl/sharded_job_dispatch_with_admission_cap_core.sv]
// sharded job dispatcher, top level: config registers, group split, front and back
// depends on sjd_pkg, sjd_front, sjd_back (and sjd_ram below it)
//
// input channel i_in_valid/o_in_ready carries one action word: submit, pop,
// complete, stop or stats, for the light or heavy worker group. every word
// gives exactly one result word on o_out_valid/i_out_ready with the status,
// popped token, shard and the group's occupancies and event counters.
// the front queue holds two classified words, so input is taken while the
// back end works and while a finished result waits in the output register.
// a pop scans the group's shards from worker_index, brought into range of the
// group's worker count, and stops at the first shard that holds a token; the
// first stop drains the overflow tokens of each group with workers into its
// shards. after a split shrinks, a submit or promote first wraps the
// round-robin pointer back into range. words are handled one at a time by the
// back end, which takes no new word until the last result is in the output register.
// reset empties every shard and overflow fifo, clears counters and the
// stopping flag, and restores the registers to 4 workers, auto split, no cap.
// a stalled receiver holds the result; the back end then waits before its
// next word and the front queue fills, after which o_in_ready drops.
// config writes on i_cfg_we take effect at once and belong in idle periods.
module sharded_job_dispatch_with_admission_cap_core #(
    parameter int MAX_WORKERS    = sjd_pkg::MAX_WORKERS_DEF,
    parameter int SHARD_DEPTH    = sjd_pkg::SHARD_DEPTH_DEF,
    parameter int OVERFLOW_DEPTH = sjd_pkg::OVERFLOW_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sjd_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sjd_pkg::t_out_word o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [8:0]         i_cfg_data
);
    import sjd_pkg::*;

    localparam int NW = $clog2(MAX_WORKERS + 1);

    logic [4:0]             r_total;
    logic [4:0]             r_heavy;
    logic [8:0]             r_cap;
    logic [4:0]             w_t;
    logic [4:0]             w_hv;
    logic [1:0][NW-1:0]     w_size;
    logic                   w_cmd_valid;
    logic                   w_cmd_ready;
    t_cmd                   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= 5'd4;
            r_heavy <= 5'd0;
            r_cap   <= 9'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TOTAL: r_total <= i_cfg_data[4:0];
                CFG_HEAVY: r_heavy <= i_cfg_data[4:0];
                CFG_CAP:   r_cap   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // worker split: heavy defaults to a quarter, at least one, but is capped to leave at least one light
    always_comb begin
        w_t = (r_total == 5'd0) ? 5'd1 : r_total;
        if (8'(w_t) > 8'(MAX_WORKERS)) begin
            w_t = 5'(MAX_WORKERS);
        end
        if (r_heavy != 5'd0) begin
            w_hv = r_heavy;
        end else begin
            w_hv = ((w_t >> 2) > 5'd1) ? (w_t >> 2) : 5'd1;
        end
        if (8'(w_hv) > 8'(MAX_WORKERS)) begin
            w_hv = 5'(MAX_WORKERS);
        end
        if (w_hv >= w_t) begin
            w_hv = w_t - 5'd1;
        end
        w_size[1] = NW'(w_hv);
        w_size[0] = NW'(w_t - w_hv);
    end

    sjd_front #(.MAX_WORKERS(MAX_WORKERS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_heavy_size (w_size[1]),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_ready  (w_cmd_ready),
        .o_cmd        (w_cmd)
    );

    sjd_back #(
        .MAX_WORKERS    (MAX_WORKERS),
        .SHARD_DEPTH    (SHARD_DEPTH),
        .OVERFLOW_DEPTH (OVERFLOW_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (w_size),
        .i_queue_cap (r_cap),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    a_popped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_POPPED |-> o_out.popped_job == '0)
        else $error("token reported without a pop");

    a_deferred_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_DEFERRED |-> o_out.overflow_count != '0)
        else $error("deferred word with empty overflow");

    a_exit_shard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_EXIT |-> o_out.shard_used == '0)
        else $error("exit status names a shard");
endmodule

[dv/tb_sharded_job_dispatch_with_admission_cap_core.sv]
// testbench for the sharded job dispatcher: directed and random action words, checked
// against an in-bench predictor of the shards, overflow fifos and counters
// depends on sjd_pkg and sharded_job_dispatch_with_admission_cap_core
module tb_sharded_job_dispatch_with_admission_cap_core;
    import sjd_pkg::*;

    localparam int NW = 16;
    localparam int SD = 16;
    localparam int OD = 64;
    localparam int CYCLE_LIMIT = 1000000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out;
    logic      i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [8:0] i_cfg_data = '0;

    sharded_job_dispatch_with_admission_cap_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // dispatcher image
    logic [15:0] shard_mem [2][NW][SD];
    int          shard_hd [2][NW];
    int          shard_n [2][NW];
    logic [15:0] ovf_mem [2][OD];
    int          ovf_hd [2];
    int          ovf_n [2];
    int          rr_ptr [2];
    int          queued [2];
    logic [31:0] n_sub [2];
    logic [31:0] n_done [2];
    logic [31:0] n_def [2];
    bit          stopping;
    int          cfg_total = 4;
    int          cfg_heavy = 0;
    int          cfg_cap = 0;

    t_out_word   pending_words[$];
    int          errors;
    int          cycles;
    int          tx_idle;
    int          rx_idle;
    int          hold_cycles;

    initial begin
        for (int g = 0; g < 2; g++) begin
            for (int s = 0; s < NW; s++) begin
                shard_hd[g][s] = 0;
                shard_n[g][s] = 0;
            end
            ovf_hd[g] = 0; ovf_n[g] = 0; rr_ptr[g] = 0; queued[g] = 0;
            n_sub[g] = '0; n_done[g] = '0; n_def[g] = '0;
        end
        stopping = 0;
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        tx_idle = 0;
        rx_idle = 0;
    end

    function automatic int workers_of(int g);
        int t;
        int h;
        t = (cfg_total == 0) ? 1 : cfg_total;
        if (t > NW) t = NW;
        if (cfg_heavy > 0) h = cfg_heavy;
        else h = (t / 4 > 1) ? t / 4 : 1;
        if (h > NW) h = NW;
        if (h >= t) h = t - 1;
        return g ? h : t - h;
    endfunction

    function automatic bit place_token(int g, logic [15:0] job, output int shard);
        int n;
        int s;
        n = workers_of(g);
        shard = 0;
        if (n == 0) return 0;
        s = rr_ptr[g] % n;
        rr_ptr[g] = (s + 1) % n;
        shard = s;
        if (shard_n[g][s] >= SD) return 0;
        shard_mem[g][s][(shard_hd[g][s] + shard_n[g][s]) % SD] = job;
        shard_n[g][s]++;
        queued[g]++;
        return 1;
    endfunction

    function automatic logic [15:0] take_overflow(int g);
        logic [15:0] job;
        job = ovf_mem[g][ovf_hd[g]];
        ovf_hd[g] = (ovf_hd[g] + 1) % OD;
        ovf_n[g]--;
        return job;
    endfunction

    function automatic t_out_word dispatch_result(t_in_word w);
        t_out_word r;
        int g;
        int n;
        int s;
        int shard;
        bit found;
        t_status st;
        r = '0;
        shard = 0;
        st = ST_QUEUED;
        g = int'(w.job_class);
        if (g == 1 && workers_of(1) == 0) g = 0;
        case (w.action)
            ACT_SUBMIT: begin
                n_sub[g]++;
                if (cfg_cap != 0 && queued[g] >= cfg_cap && !stopping) begin
                    n_def[g]++;
                    if (ovf_n[g] < OD) begin
                        ovf_mem[g][(ovf_hd[g] + ovf_n[g]) % OD] = w.job_id;
                        ovf_n[g]++;
                        st = ST_DEFERRED;
                    end else begin
                        st = ST_DROPPED;
                    end
                end else begin
                    st = place_token(g, w.job_id, shard) ? ST_QUEUED : ST_DROPPED;
                end
            end
            ACT_POP: begin
                n = workers_of(g);
                found = 0;
                for (int k = 0; k < n && !found; k++) begin
                    s = (int'(w.worker_index) + k) % n;
                    if (shard_n[g][s] != 0) begin
                        r.popped_job = shard_mem[g][s][shard_hd[g][s]];
                        shard_hd[g][s] = (shard_hd[g][s] + 1) % SD;
                        shard_n[g][s]--;
                        if (queued[g] > 0) queued[g]--;
                        shard = s;
                        found = 1;
                    end
                end
                st = found ? ST_POPPED : (stopping ? ST_EXIT : ST_EMPTY);
            end
            ACT_COMPLETE: begin
                n_done[g]++;
                st = ST_EMPTY;
                if ((cfg_cap == 0 || queued[g] < cfg_cap) && ovf_n[g] != 0
                    && workers_of(g) != 0) begin
                    st = place_token(g, take_overflow(g), shard) ? ST_QUEUED : ST_DROPPED;
                end
            end
            ACT_STOP: begin
                st = ST_EXIT;
                if (!stopping) begin
                    stopping = 1;
                    for (int h = 0; h < 2; h++) begin
                        if (workers_of(h) != 0) begin
                            while (ovf_n[h] != 0) begin
                                if (!place_token(h, take_overflow(h), s)) st = ST_DROPPED;
                            end
                        end
                    end
                end
                shard = 0;
            end
            default: st = ST_QUEUED;
        endcase
        r.status = st;
        r.shard_used = shard[3:0];
        r.queued_count = queued[g][8:0];
        r.overflow_count = ovf_n[g][6:0];
        r.submitted_total = n_sub[g];
        r.completed_total = n_done[g];
        r.deferred_total = n_def[g];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_word w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", 32'd0, 32'd0);
            end else begin
                w = pending_words[0];
                pending_words.delete(0);
                if (o_out.status !== w.status)
                    report_mismatch("status", 32'(o_out.status), 32'(w.status));
                if (o_out.popped_job !== w.popped_job)
                    report_mismatch("popped_job", 32'(o_out.popped_job), 32'(w.popped_job));
                if (o_out.shard_used !== w.shard_used)
                    report_mismatch("shard_used", 32'(o_out.shard_used), 32'(w.shard_used));
                if (o_out.queued_count !== w.queued_count)
                    report_mismatch("queued_count", 32'(o_out.queued_count),
                                    32'(w.queued_count));
                if (o_out.overflow_count !== w.overflow_count)
                    report_mismatch("overflow_count", 32'(o_out.overflow_count),
                                    32'(w.overflow_count));
                if (o_out.submitted_total !== w.submitted_total)
                    report_mismatch("submitted_total", o_out.submitted_total,
                                    w.submitted_total);
                if (o_out.completed_total !== w.completed_total)
                    report_mismatch("completed_total", o_out.completed_total,
                                    w.completed_total);
                if (o_out.deferred_total !== w.deferred_total)
                    report_mismatch("deferred_total", o_out.deferred_total, w.deferred_total);
            end
        end
    end

    // receiver; a long hold-off counts down here
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < tx_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (!o_in_ready);
        pending_words.insert(pending_words.size(), dispatch_result(w));
    endtask

    task automatic send_action(t_action a, logic [15:0] job, logic cls, logic [3:0] widx);
        t_in_word w;
        w.action = a;
        w.job_id = job;
        w.job_class = cls;
        w.worker_index = widx;
        send_word(w);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(int total, int heavy, int cap);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_TOTAL;
        i_cfg_data <= total[8:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_HEAVY;
        i_cfg_data <= heavy[8:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_CAP;
        i_cfg_data <= cap[8:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_total = total & 'h1f;
        cfg_heavy = heavy & 'h1f;
        cfg_cap = cap & 'h1ff;
        @(posedge i_clk);
    endtask

    function automatic t_in_word random_word();
        t_in_word w;
        int r;
        r = $urandom_range(99);
        w.job_id = 16'($urandom);
        w.job_class = 1'($urandom);
        w.worker_index = 4'($urandom);
        if (r < 40) w.action = ACT_SUBMIT;
        else if (r < 70) w.action = ACT_POP;
        else if (r < 90) w.action = ACT_COMPLETE;
        else if (r < 95) w.action = ACT_STATS;
        else w.action = 3'($urandom_range(7, 5));
        return w;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_word(random_word());
    endtask

    task automatic test_directed();
        send_action(ACT_POP, 16'h0, 1'b0, 4'd15);
        send_action(ACT_POP, 16'h0, 1'b1, 4'd0);
        send_action(ACT_COMPLETE, 16'h0, 1'b0, 4'd0);
        send_action(ACT_SUBMIT, 16'h0000, 1'b0, 4'd0);
        send_action(ACT_SUBMIT, 16'hffff, 1'b1, 4'd15);
        send_action(ACT_SUBMIT, 16'h5a5a, 1'b0, 4'd7);
        send_action(ACT_STATS, 16'h1234, 1'b1, 4'd3);
        send_action(t_action'(3'd7), 16'hffff, 1'b1, 4'd15);
        send_action(ACT_POP, 16'h0, 1'b0, 4'd2);
        send_action(ACT_POP, 16'h0, 1'b1, 4'd15);
        send_action(ACT_POP, 16'h0, 1'b0, 4'd15);
        // cap of one: the second and third submits park, and each complete after a pop promotes one
        write_cfg(4, 0, 1);
        send_action(ACT_SUBMIT, 16'ha5a5, 1'b0, 4'd0);
        send_action(ACT_SUBMIT, 16'h8001, 1'b0, 4'd0);
        send_action(ACT_SUBMIT, 16'h7ffe, 1'b0, 4'd0);
        send_action(ACT_COMPLETE, 16'h0, 1'b0, 4'd0);
        send_action(ACT_POP, 16'h0, 1'b0, 4'd1);
        send_action(ACT_COMPLETE, 16'h0, 1'b0, 4'd0);
        send_action(ACT_POP, 16'h0, 1'b0, 4'd0);
        send_action(ACT_POP, 16'h0, 1'b0, 4'd0);
        send_action(ACT_COMPLETE, 16'h0, 1'b0, 4'd0);
    endtask

    task automatic test_random_splits();
        tx_idle = 38; rx_idle = 82;
        write_cfg(16, 0, 8);
        run_random(250);
        write_cfg(1, 0, 0);
        run_random(250);
        tx_idle = 82; rx_idle = 38;
        write_cfg(16, 16, 256);
        run_random(250);
        write_cfg(0, 31, 1);
        run_random(250);
        tx_idle = 0; rx_idle = 0;
        write_cfg(5, 2, 3);
        run_random(200);
        write_cfg(16, 1, 0);
        run_random(150);
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_cycles = 400;
        repeat (30) send_word(random_word());
    endtask

    task automatic test_stop();
        // heavy overflow built here is stranded once the heavy group vanishes
        write_cfg(4, 1, 1);
        repeat (6) send_action(ACT_SUBMIT, 16'($urandom), 1'b1, 4'd0);
        repeat (6) send_action(ACT_SUBMIT, 16'($urandom), 1'b0, 4'd0);
        write_cfg(1, 0, 1);
        send_action(ACT_STOP, 16'h0, 1'b0, 4'd0);
        send_action(ACT_STOP, 16'h0, 1'b1, 4'd0);
        send_action(ACT_SUBMIT, 16'h4242, 1'b0, 4'd0);
        write_cfg(4, 1, 1);
        send_action(ACT_STATS, 16'h0, 1'b1, 4'd0);
        rx_idle = 50;
        repeat (60) begin
            send_action(ACT_POP, 16'h0, 1'($urandom), 4'($urandom));
        end
        run_random(60);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_splits();
        test_backpressure();
        test_stop();
        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
